FILE: hw/rtl/setpoint_hold_extrapolator_defines.svh
// assertion macros for the setpoint hold extrapolator
`ifndef SETPOINT_HOLD_EXTRAPOLATOR_DEFINES_SVH
`define SETPOINT_HOLD_EXTRAPOLATOR_DEFINES_SVH
`ifndef SYNTH
`define SHE_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SHE_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SHE_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define SHE_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

FILE: hw/rtl/she_pkg.sv
`timescale 1ns / 1ps
package she_pkg;
  localparam logic [1:0] CMD_SETPOINT = 2'd0;
  localparam logic [1:0] CMD_EVAL     = 2'd1;
  localparam logic [1:0] CMD_RESET    = 2'd2;
  localparam logic [1:0] MODE_ZERO    = 2'd0;
  localparam logic [1:0] MODE_FIRST   = 2'd1;
  localparam logic [1:0] MODE_SECOND  = 2'd2;
  localparam logic [1:0] MODE_OVERRIDE = 2'd3;
  localparam int IO_W = 32;
  localparam int FRAC = 16;
  localparam int IN_W = 2 + 4 * IO_W;
  localparam int OUT_W = 9 * IO_W;
  localparam logic [3:0] OP_DIV = 4'd0;
  localparam logic [3:0] OP_MUL = 4'd1;
  typedef struct packed {
    logic       start;
    logic [3:0] op;
  } lane_ctl_t;
endpackage

FILE: hw/rtl/she_lane.sv
`timescale 1ns / 1ps
`include "setpoint_hold_extrapolator_defines.svh"
module she_lane #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  she_pkg::lane_ctl_t   ctl,
  input  logic signed [W:0]    opa,
  input  logic signed [W:0]    opb,
  output logic                 busy,
  output logic signed [W-1:0]  res
);
  import she_pkg::*;
  localparam int MW = W + 1;
  localparam int QW = W + FRAC + 2;
  localparam int PW = QW + MW;
  localparam int CW = $clog2(QW + 1);
  localparam logic [QW-1:0] HI_MAG = QW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [QW-1:0] LO_MAG = QW'(64'd1 << (W - 1));

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, op_r, op_nxt, neg_r, neg_nxt;
  logic [QW-1:0] acc_r, acc_nxt, quo_r, quo_nxt;
  logic [MW-1:0] b_r, b_nxt;
  logic [PW-1:0] prd_r, prd_nxt;
  logic [MW-1:0] am, bm;
  logic [QW:0]   trial;
  logic [QW-1:0] mag;
  logic [PW-1:0] pshift;

  assign am = opa[W] ? MW'(-opa) : MW'(opa);
  assign bm = opb[W] ? MW'(-opb) : MW'(opb);
  assign trial = {acc_r[QW-2:0], quo_r[QW-1]} - {{(QW+1-MW){1'b0}}, b_r};
  assign pshift = prd_r >> FRAC;

  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; op_nxt = op_r; neg_nxt = neg_r;
    acc_nxt = acc_r; quo_nxt = quo_r; b_nxt = b_r; prd_nxt = prd_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt = (ctl.op == OP_MUL);
      neg_nxt = opa[W] ^ opb[W];
      b_nxt = bm;
      acc_nxt = '0;
      quo_nxt = {{(QW-MW-FRAC){1'b0}}, am, {FRAC{1'b0}}};
      prd_nxt = '0;
      cnt_nxt = (ctl.op == OP_MUL) ? CW'(MW) : CW'(QW);
    end else if (busy_r) begin
      if (op_r) begin
        prd_nxt = {prd_r[PW-2:0], 1'b0} +
                  (quo_r[MW+FRAC-1] ? {{(PW-MW){1'b0}}, b_r} : '0);
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end else begin
        if (!trial[QW]) begin
          acc_nxt = trial[QW-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[QW-2:0], quo_r[QW-1]};
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_comb begin
    if (op_r) begin
      mag = (|pshift[PW-1:QW]) ? {QW{1'b1}} : pshift[QW-1:0];
    end else begin
      mag = quo_r;
    end
    if (neg_r) res = (mag >= LO_MAG) ? -W'(LO_MAG) : -W'(mag);
    else res = (mag > HI_MAG) ? W'(HI_MAG) : W'(mag);
  end

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    op_r <= op_nxt; neg_r <= neg_nxt; acc_r <= acc_nxt;
    quo_r <= quo_nxt; b_r <= b_nxt; prd_r <= prd_nxt;
  end

  `SHE_ASSERT_NXT(a_start_busy, clk, rst_n, ctl.start, busy_r, "lane not busy after start")
  `SHE_ASSERT_IMP(a_cnt_idle, clk, rst_n, !busy_r, cnt_r == '0, "lane count left over")
  `SHE_ASSERT_IMP(a_no_restart, clk, rst_n, busy_r, !ctl.start, "lane restarted while busy")
endmodule

FILE: hw/rtl/setpoint_hold_extrapolator.sv
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       slave      in_tvalid/in_tready    tdata: command, time, pos x y z
// out      master     out_tvalid/out_tready  tdata: pos x y z, vel x y z, acc x y z
// cfg      slave      cfg_valid/cfg_ready    hold_mode
// one item at a time; one lane per axis plus a spare lane for d*d
// evaluation: the lanes run the product passes S_SQ, S_M1 and S_M2 in turn, then the result is registered
// setpoint: divides by dt in S_D1 in first and second order when dt > 0, and again in S_D2 in second order
// reset and unused command stay in idle; synchronous reset clears control and setpoint state, mode first order
// a waiting result holds in out_tdata; the block stalls only when a new result finds it waiting
`include "setpoint_hold_extrapolator_defines.svh"
module setpoint_hold_extrapolator #(
  parameter int AXES = 3,
  parameter int WORD_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // command, time_value, pos_x, pos_y, pos_z
  input  logic [she_pkg::IN_W+5:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // out_pos_x/y/z, out_vel_x/y/z, out_acc_x/y/z
  output logic [she_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_data
);
  import she_pkg::*;
  localparam int W = WORD_WIDTH;
  localparam int NL = AXES + 1;
  localparam logic [3:0] S_IDLE = 4'd0, S_D1 = 4'd1, S_D1W = 4'd2, S_D2 = 4'd3,
    S_D2W = 4'd4, S_SQ = 4'd5, S_SQW = 4'd6, S_M1 = 4'd7, S_M1W = 4'd8,
    S_M2 = 4'd9, S_M2W = 4'd10, S_OUT = 4'd11;
  localparam logic signed [W:0] HI = (W+1)'((64'd1 << (W - 1)) - 64'd1);
  localparam logic signed [W:0] LO = -HI - (W+1)'(1);

  logic [3:0] st_r, st_nxt;
  logic [1:0] mode_r;
  logic signed [W-1:0] ct_r, pt_r;
  logic signed [W:0]   dt_r, d_r;
  logic signed [W-1:0] dd_r;
  logic signed [W-1:0] cp_r [AXES], cs_r [AXES], cc_r [AXES];
  logic signed [W-1:0] pp_r [AXES], ps_r [AXES];
  logic signed [W:0]   sum_r [AXES];
  logic signed [W-1:0] pos_r [AXES], vel_r [AXES];
  logic [OUT_W-1:0] od_r, od_nxt;
  logic ov_r;
  lane_ctl_t ctl [NL];
  logic signed [W:0] la [NL], lb [NL];
  logic busy [NL];
  logic signed [W-1:0] lr [NL];
  logic any_busy;
  logic div_go;
  logic out_load;
  logic [1:0] cmd;
  logic signed [W-1:0] tin;
  logic signed [W-1:0] pin [AXES];

  function automatic logic signed [W-1:0] sat_in(input logic [IO_W-1:0] v);
    logic signed [W+IO_W:0] e;
    e = (W+IO_W+1)'($signed(v));
    if (e > (W+IO_W+1)'(HI)) return HI[W-1:0];
    if (e < (W+IO_W+1)'(LO)) return LO[W-1:0];
    return e[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
    if (v > (W+2)'(HI)) return HI[W-1:0];
    if (v < (W+2)'(LO)) return LO[W-1:0];
    return v[W-1:0];
  endfunction

  assign cmd = in_tdata[1:0];
  assign tin = sat_in(in_tdata[2+IO_W-1:2]);
  for (genvar a = 0; a < AXES; a++) begin : g_pin
    if (a < 3) begin : g_y
      assign pin[a] = sat_in(in_tdata[2+IO_W*(a+2)-1 -: IO_W]);
    end else begin : g_n
      assign pin[a] = '0;
    end
  end

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < NL; i++) any_busy = any_busy | busy[i];
  end

  assign div_go = (mode_r == MODE_FIRST || mode_r == MODE_SECOND) && dt_r > 0;
  assign out_load = (st_r == S_OUT) && (!ov_r || out_tready);
  assign in_tready = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_tvalid) begin
        if (cmd == CMD_EVAL) st_nxt = S_SQ;
        else if (cmd == CMD_SETPOINT) st_nxt = S_D1;
      end
      S_D1: st_nxt = div_go ? S_D1W : S_IDLE;
      S_D1W: if (!any_busy) st_nxt = (mode_r == MODE_SECOND) ? S_D2 : S_IDLE;
      S_D2: st_nxt = S_D2W;
      S_D2W: if (!any_busy) st_nxt = S_IDLE;
      S_SQ: st_nxt = S_SQW;
      S_SQW: if (!any_busy) st_nxt = S_M1;
      S_M1: st_nxt = S_M1W;
      S_M1W: if (!any_busy) st_nxt = S_M2;
      S_M2: st_nxt = S_M2W;
      S_M2W: if (!any_busy) st_nxt = S_OUT;
      S_OUT: if (!ov_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      ctl[i] = '{start: 1'b0, op: OP_MUL};
      la[i] = '0; lb[i] = '0;
    end
    for (int i = 0; i < AXES; i++) begin
      if (st_r == S_D1 && div_go) begin
        ctl[i] = '{start: 1'b1, op: OP_DIV};
        la[i] = (W+1)'(cp_r[i]) - (W+1)'(pp_r[i]); lb[i] = dt_r;
      end
      if (st_r == S_D2) begin
        ctl[i] = '{start: 1'b1, op: OP_DIV};
        la[i] = (W+1)'(cs_r[i]) - (W+1)'(ps_r[i]); lb[i] = dt_r;
      end
      if (st_r == S_SQ) begin
        ctl[i] = '{start: 1'b1, op: OP_MUL};
        la[i] = (W+1)'(cs_r[i]); lb[i] = d_r;
      end
      if (st_r == S_M1) begin
        ctl[i] = '{start: 1'b1, op: OP_MUL};
        la[i] = (W+1)'(cc_r[i]); lb[i] = (W+1)'(dd_r);
      end
      if (st_r == S_M2) begin
        ctl[i] = '{start: 1'b1, op: OP_MUL};
        la[i] = (W+1)'(cc_r[i]); lb[i] = d_r;
      end
    end
    if (st_r == S_SQ) begin
      ctl[AXES] = '{start: 1'b1, op: OP_MUL}; la[AXES] = d_r; lb[AXES] = d_r;
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    she_lane #(.W(W)) u_lane (
      .clk(clk), .rst_n(rst_n), .ctl(ctl[l]), .opa(la[l]), .opb(lb[l]),
      .busy(busy[l]), .res(lr[l])
    );
  end

  always_comb begin
    od_nxt = '0;
    for (int i = 0; i < AXES && i < 3; i++) begin
      od_nxt[IO_W*i +: IO_W]     = IO_W'((mode_r == MODE_OVERRIDE) ? cp_r[i] : pos_r[i]);
      od_nxt[IO_W*(3+i) +: IO_W] = IO_W'((mode_r == MODE_OVERRIDE) ? cs_r[i] : vel_r[i]);
      od_nxt[IO_W*(6+i) +: IO_W] = IO_W'(cc_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; mode_r <= MODE_FIRST; ov_r <= 1'b0;
      ct_r <= '0; pt_r <= '0; dt_r <= '0; d_r <= '0; dd_r <= '0;
      for (int i = 0; i < AXES; i++) begin
        cp_r[i] <= '0; cs_r[i] <= '0; cc_r[i] <= '0; pp_r[i] <= '0;
        ps_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) mode_r <= cfg_data;
      if (out_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      if (st_r == S_IDLE && in_tvalid) begin
        if (cmd == CMD_RESET) begin
          ct_r <= tin; pt_r <= '0;
          for (int i = 0; i < AXES; i++) begin
            cp_r[i] <= '0; cs_r[i] <= '0; cc_r[i] <= '0; pp_r[i] <= '0; ps_r[i] <= '0;
          end
        end else if (cmd == CMD_SETPOINT) begin
          if (tin > ct_r) begin
            pt_r <= ct_r;
            dt_r <= (W+1)'(tin) - (W+1)'(ct_r);
            for (int i = 0; i < AXES; i++) begin
              pp_r[i] <= cp_r[i]; ps_r[i] <= cs_r[i];
            end
          end else begin
            dt_r <= (W+1)'(tin) - (W+1)'(pt_r);
          end
          ct_r <= tin;
          for (int i = 0; i < AXES; i++) begin
            cp_r[i] <= pin[i]; cs_r[i] <= '0; cc_r[i] <= '0;
          end
        end else if (cmd == CMD_EVAL) begin
          d_r <= (W+1)'(tin) - (W+1)'(ct_r);
        end
      end
      if (st_r == S_D1W && !any_busy)
        for (int i = 0; i < AXES; i++) cs_r[i] <= lr[i];
      if (st_r == S_D2W && !any_busy)
        for (int i = 0; i < AXES; i++) cc_r[i] <= lr[i];
      if (st_r == S_SQW && !any_busy) dd_r <= lr[AXES];
    end
  end

  // position and velocity sums, one product pass at a time
  always_ff @(posedge clk) begin
    if (st_r == S_SQW && !any_busy)
      for (int i = 0; i < AXES; i++) sum_r[i] <= (W+1)'(cp_r[i]) + (W+1)'(lr[i]);
    if (st_r == S_M1W && !any_busy)
      for (int i = 0; i < AXES; i++) pos_r[i] <= sat2((W+2)'(sum_r[i]) + (W+2)'(lr[i]));
    if (st_r == S_M2W && !any_busy)
      for (int i = 0; i < AXES; i++) vel_r[i] <= sat2((W+2)'(cs_r[i]) + (W+2)'(lr[i]));
    if (out_load) od_r <= od_nxt;
  end

  `SHE_ASSERT_IMP(a_busy_ready, clk, rst_n, any_busy, !in_tready, "item taken while lanes busy")
  `SHE_ASSERT_NXT(a_hold_out, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `SHE_ASSERT_NXT(a_hold_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
endmodule
